### rtl/lmts_pkg.sv
// shared types and constants for the lcd mode timing sequencer
`timescale 1ns / 1ps

package lmts_pkg;

  // field widths
  localparam int CYC_W   = 8;
  localparam int CNT_W   = 16;
  localparam int LINE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 2;
  localparam int CDATA_W = 8;
  localparam int OUT_W   = 16;

  // mode lengths in dot cycles
  localparam logic [CNT_W-1:0] LEN_OAM    = CNT_W'(80);
  localparam logic [CNT_W-1:0] LEN_XFER   = CNT_W'(172);
  localparam logic [CNT_W-1:0] LEN_HBLANK = CNT_W'(204);
  localparam logic [CNT_W-1:0] LEN_VLINE  = CNT_W'(456);
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  // line numbers
  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = LINE_W'(144);
  localparam logic [LINE_W-1:0] LAST_LINE         = LINE_W'(153);

  // reported mode codes
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DISPLAY_ENABLE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_LINE_COMPARE       = 2'd1;
  localparam logic [IDX_W-1:0] REG_COMPARE_IRQ_ENABLE = 2'd2;

  // one-hot scan state
  typedef enum logic [3:0] {
    ST_HBLANK = 4'b0001,
    ST_VBLANK = 4'b0010,
    ST_OAM    = 4'b0100,
    ST_XFER   = 4'b1000
  } scan_state_t;

  // configuration register contents
  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] line_compare;
    logic              compare_irq_enable;
  } lcd_cfg_t;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic              frame_restart;
    logic              frame_ready;
    logic              stat_irq;
    logic              vblank_irq;
    logic              blank_bit;
    logic              coincidence;
    logic [LINE_W-1:0] line;
    logic [MODE_W-1:0] mode;
  } lcd_res_t;

endpackage

### rtl/lmts_cfg_regs.sv
// configuration register file of the lcd mode timing sequencer
`timescale 1ns / 1ps

module lmts_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lmts_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lmts_pkg::CDATA_W-1:0] cfg_data,
  output lmts_pkg::lcd_cfg_t           cfg
);
  import lmts_pkg::*;

  lcd_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register write decode, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DISPLAY_ENABLE:     cfg_r.display_enable     <= cfg_data[0];
        REG_LINE_COMPARE:       cfg_r.line_compare       <= cfg_data[LINE_W-1:0];
        REG_COMPARE_IRQ_ENABLE: cfg_r.compare_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/lmts_core.sv
// scan timing state, next-state logic and result register
`timescale 1ns / 1ps

module lmts_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       step,
  input  logic [lmts_pkg::CYC_W-1:0] cycles,
  input  lmts_pkg::lcd_cfg_t         cfg,
  output logic                       res_valid,
  output lmts_pkg::lcd_res_t         res
);
  import lmts_pkg::*;

  scan_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              match_r, match_nxt;
  logic              blank_r, blank_nxt;
  logic              res_valid_r;
  lcd_res_t          res_r, res_nxt;

  logic [CNT_W:0]    sum;
  logic [CNT_W-1:0]  cnt_sat;
  logic [LINE_W-1:0] line_inc;
  logic              vblank_irq, stat_irq, frame_restart;
  logic [MODE_W-1:0] mode_code;

  // saturating add of the elapsed cycles
  assign sum      = {1'b0, cnt_r} + {{(CNT_W+1-CYC_W){1'b0}}, cycles};
  assign cnt_sat  = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  assign line_inc = line_r + LINE_W'(1);

  // at most one mode transition per tick
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_sat;
    line_nxt      = line_r;
    match_nxt     = match_r;
    blank_nxt     = blank_r;
    vblank_irq    = 1'b0;
    stat_irq      = 1'b0;
    frame_restart = 1'b0;
    if (cfg.display_enable) begin
      unique case (state_r)
        ST_HBLANK: begin
          if (cnt_sat >= LEN_HBLANK) begin
            cnt_nxt   = cnt_sat - LEN_HBLANK;
            line_nxt  = line_inc;
            blank_nxt = 1'b0;
            match_nxt = (line_inc == cfg.line_compare);
            stat_irq  = match_nxt && cfg.compare_irq_enable;
            if (line_inc == FIRST_VBLANK_LINE) begin
              vblank_irq = 1'b1;
              state_nxt  = ST_VBLANK;
            end else begin
              state_nxt  = ST_OAM;
            end
          end
        end
        ST_VBLANK: begin
          if (cnt_sat >= LEN_VLINE) begin
            cnt_nxt   = cnt_sat - LEN_VLINE;
            blank_nxt = 1'b1;
            if (line_inc > LAST_LINE) begin
              // wrap into a new frame
              line_nxt      = '0;
              state_nxt     = ST_OAM;
              frame_restart = 1'b1;
              match_nxt     = 1'b0;
            end else begin
              line_nxt  = line_inc;
              match_nxt = (line_inc == cfg.line_compare) && (line_inc != '0);
            end
          end
        end
        ST_OAM: begin
          if (cnt_sat >= LEN_OAM) begin
            cnt_nxt   = cnt_sat - LEN_OAM;
            state_nxt = ST_XFER;
          end
        end
        ST_XFER: begin
          if (cnt_sat >= LEN_XFER) begin
            cnt_nxt   = cnt_sat - LEN_XFER;
            state_nxt = ST_HBLANK;
          end
        end
        default: state_nxt = ST_HBLANK;
      endcase
    end
  end

  // reported mode code of the next state
  always_comb begin
    unique case (state_nxt)
      ST_HBLANK: mode_code = MODE_HBLANK;
      ST_VBLANK: mode_code = MODE_VBLANK;
      ST_OAM:    mode_code = MODE_OAM;
      ST_XFER:   mode_code = MODE_XFER;
      default:   mode_code = MODE_HBLANK;
    endcase
  end

  // result assembly
  always_comb begin
    res_nxt.mode          = mode_code;
    res_nxt.line          = line_nxt;
    res_nxt.coincidence   = match_nxt;
    res_nxt.blank_bit     = blank_nxt;
    res_nxt.vblank_irq    = vblank_irq;
    res_nxt.stat_irq      = stat_irq;
    res_nxt.frame_ready   = vblank_irq;
    res_nxt.frame_restart = frame_restart;
  end

  // timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HBLANK;
      cnt_r   <= '0;
      line_r  <= '0;
      match_r <= 1'b0;
      blank_r <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      line_r  <= line_nxt;
      match_r <= match_nxt;
      blank_r <= blank_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### rtl/lcd_mode_timing_sequencer.sv
// top level of the lcd mode timing sequencer
// path: an accepted tick passes the input register, then the result register
// throughput: one tick per cycle unless out_tready stalls; the line/mode state is
//   updated in a single pass between the input register and the result register
// reset: synchronous active-low rst_n clears the counter, mode (hblank), line,
//   flags, configuration registers and both valid bits
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream, tdata: cycles[7:0]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [lmts_pkg::CYC_W-1:0]   in_tdata,
  // result stream, tdata: mode[1:0] line[9:2] coincidence[10] blank_bit[11]
  //   vblank_irq[12] stat_irq[13] frame_ready[14] frame_restart[15]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lmts_pkg::OUT_W-1:0]   out_tdata,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lmts_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lmts_pkg::CDATA_W-1:0] cfg_data
);
  import lmts_pkg::*;

  lcd_cfg_t         cfg;
  lcd_res_t         res;
  logic             res_valid;
  logic             adv;
  logic             in_valid_r;
  logic [CYC_W-1:0] in_cycles_r;

  // whole pipe moves when the result slot is free or being taken
  assign adv       = !res_valid || out_tready;
  assign in_tready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tvalid) begin
      in_cycles_r <= in_tdata;
    end
  end

  lmts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .step      (in_valid_r && adv),
    .cycles    (in_cycles_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = res;

  // vblank interrupt only on entry to line 144 in vblank
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.vblank_irq) |->
      (res.line == FIRST_VBLANK_LINE && res.mode == MODE_VBLANK && res.frame_ready))
    else $error("vblank pulse outside line 144 entry");

  // frame restart lands on line zero in oam
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.frame_restart) |->
      (res.line == '0 && res.mode == MODE_OAM && res.blank_bit))
    else $error("frame restart without wrap to line zero");

  // compare interrupt needs the stored coincidence and enable
  a_stat_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.stat_irq) |-> (res.coincidence && cfg.compare_irq_enable))
    else $error("compare interrupt without coincidence");

  // line never leaves the scan range
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.line <= LAST_LINE))
    else $error("line beyond last scanline");

endmodule

### tb/lcd_mode_timing_sequencer_tb.sv
// self-checking testbench for the lcd mode timing sequencer
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_tb;
  import lmts_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;  // no register behind this index
  localparam int QUIET_LIMIT = 2000;                // cycles without any transaction
  localparam int LONG_HOLD   = 300;                 // long receiver back-pressure
  localparam int HOLD_AFTER  = 60;                  // results seen before the long hold
  localparam int DRAIN_WAIT  = 8;                   // cycles after the last result

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [CYC_W-1:0]    in_tdata = '0;   // cycles[7:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;       // mode line coincidence blank_bit and pulses
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CDATA_W-1:0]  cfg_data = '0;

  lcd_mode_timing_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ticks waiting to be sent and status words waiting to come back
  logic [CYC_W-1:0] tick_q [$];
  lcd_res_t         scan_status_q [$];

  // mirror of the scan timing state and the registers
  logic [CNT_W-1:0]  dot_cnt = '0;
  logic [MODE_W-1:0] scan_mode = MODE_HBLANK;
  logic [LINE_W-1:0] scan_line = '0;
  logic              coin_flag = 1'b0;
  logic              vblank_flag = 1'b0;
  logic              disp_en = 1'b0;
  logic [LINE_W-1:0] lyc = '0;
  logic              lyc_irq_en = 1'b0;

  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit no_idle = 1'b0;
  bit long_hold_due = 1'b1;
  bit run_done = 1'b0;
  bit timed_out = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  // mostly short gaps, now and then a long one
  function automatic int draw_gap(int pct_zero);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < pct_zero) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  // one tick: add the dot cycles, then take at most one mode transition
  function automatic lcd_res_t advance_scan_timing(logic [CYC_W-1:0] cyc);
    lcd_res_t     res;
    logic [CNT_W:0] sum;
    res = '0;
    sum = {1'b0, dot_cnt} + {{(CNT_W+1-CYC_W){1'b0}}, cyc};
    dot_cnt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    if (disp_en) begin
      case (scan_mode)
        MODE_HBLANK: begin
          if (dot_cnt >= LEN_HBLANK) begin
            dot_cnt = dot_cnt - LEN_HBLANK;
            scan_mode = MODE_OAM;
            scan_line = scan_line + LINE_W'(1);
            vblank_flag = 1'b0;
            coin_flag = (scan_line == lyc);
            res.stat_irq = coin_flag && lyc_irq_en;
            if (scan_line == FIRST_VBLANK_LINE) begin
              res.vblank_irq = 1'b1;
              res.frame_ready = 1'b1;
              scan_mode = MODE_VBLANK;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot_cnt >= LEN_VLINE) begin
            scan_line = scan_line + LINE_W'(1);
            // past the last line the frame starts over
            if (scan_line > LAST_LINE) begin
              scan_line = '0;
              scan_mode = MODE_OAM;
              res.frame_restart = 1'b1;
            end
            vblank_flag = 1'b1;
            coin_flag = (scan_line == lyc) && (scan_line != '0);
            dot_cnt = dot_cnt - LEN_VLINE;
          end
        end
        MODE_OAM: begin
          if (dot_cnt >= LEN_OAM) begin
            dot_cnt = dot_cnt - LEN_OAM;
            scan_mode = MODE_XFER;
          end
        end
        default: begin
          if (dot_cnt >= LEN_XFER) begin
            dot_cnt = dot_cnt - LEN_XFER;
            scan_mode = MODE_HBLANK;
          end
        end
      endcase
    end
    res.mode = scan_mode;
    res.line = scan_line;
    res.coincidence = coin_flag;
    res.blank_bit = vblank_flag;
    return res;
  endfunction

  function automatic void apply_register(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    case (idx)
      REG_DISPLAY_ENABLE:     disp_en = val[0];
      REG_LINE_COMPARE:       lyc = val;
      REG_COMPARE_IRQ_ENABLE: lyc_irq_en = val[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  function automatic void compare_status(logic [OUT_W-1:0] word);
    lcd_res_t got;
    lcd_res_t exp;
    got = word;
    if (scan_status_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, word);
      mismatches++;
      return;
    end
    exp = scan_status_q.pop_front();
    check_field("mode", int'(exp.mode), int'(got.mode));
    check_field("line", int'(exp.line), int'(got.line));
    check_field("coincidence", int'(exp.coincidence), int'(got.coincidence));
    check_field("blank_bit", int'(exp.blank_bit), int'(got.blank_bit));
    check_field("vblank_irq", int'(exp.vblank_irq), int'(got.vblank_irq));
    check_field("stat_irq", int'(exp.stat_irq), int'(got.stat_irq));
    check_field("frame_ready", int'(exp.frame_ready), int'(got.frame_ready));
    check_field("frame_restart", int'(exp.frame_restart), int'(got.frame_restart));
  endfunction

  // sample every channel, predict, check and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_tvalid && in_tready;
      cfg_taken = cfg_valid && cfg_ready;
      if (in_taken) scan_status_q.push_back(advance_scan_timing(in_tdata));
      if (cfg_taken) apply_register(cfg_index, cfg_data);
      if (out_tvalid && out_tready) begin
        compare_status(out_tdata);
        results_seen++;
      end
      if (in_taken || cfg_taken || (out_tvalid && out_tready)) quiet_cycles = 0;
      else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
      end
    end
  end

  // tick driver, one transaction per item with random gaps between
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= tick_q.pop_front();
        send_gap = draw_gap(60);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (long_hold_due && results_seen >= HOLD_AFTER) begin
      long_hold_due = 1'b0;
      stall_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left = draw_gap(75);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // wait until no tick is pending and every status word has come back
  task automatic wait_idle();
    do @(negedge clk); while (tick_q.size() != 0 || in_tvalid || scan_status_q.size() != 0);
  endtask

  task automatic run_phase(input logic en, input logic [LINE_W-1:0] lc, input logic irq,
                           input int count, input int lo, input int hi, input bit mixed,
                           input bit quiet);
    wait_idle();
    write_register(REG_DISPLAY_ENABLE, {7'($urandom), en});
    write_register(REG_LINE_COMPARE, lc);
    write_register(REG_COMPARE_IRQ_ENABLE, {7'($urandom), irq});
    no_idle = quiet;
    @(posedge clk);
    repeat (count) begin
      if (mixed && $urandom_range(0, 7) == 0) tick_q.push_back(CYC_W'($urandom));
      else tick_q.push_back(CYC_W'($urandom_range(lo, hi)));
    end
  endtask

  // stimulus: directed ticks, then random phases under several settings
  initial begin
    logic [CYC_W-1:0] off_ticks [5] = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1};
    logic [CYC_W-1:0] on_ticks [14] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd80, 8'd172,
                                        8'd204, 8'd0, 8'd0, 8'd128, 8'd127, 8'd254, 8'd2};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // display still off after reset: only the counter moves
    foreach (off_ticks[i]) tick_q.push_back(off_ticks[i]);
    wait_idle();
    write_register(REG_UNUSED, 8'hFF);
    write_register(REG_DISPLAY_ENABLE, 8'h01);
    write_register(REG_LINE_COMPARE, 8'd1);
    write_register(REG_COMPARE_IRQ_ENABLE, 8'h01);
    @(posedge clk);
    foreach (on_ticks[i]) tick_q.push_back(on_ticks[i]);

    run_phase(1'b1, LINE_W'($urandom_range(2, 143)), 1'b1, 200, 0, 255, 1'b0, 1'b0);
    // display off with large ticks drives the counter into saturation
    run_phase(1'b0, 8'd255, 1'b0, 270, 240, 255, 1'b0, 1'b0);
    // saturated counter: one transition per tick, passes a frame wrap
    run_phase(1'b1, 8'd0, 1'b1, 450, 160, 255, 1'b1, 1'b0);
    run_phase(1'b1, FIRST_VBLANK_LINE, 1'b1, 60, 160, 255, 1'b1, 1'b1);
    run_phase(1'b1, LAST_LINE, 1'b0, 80, 0, 255, 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    run_done = 1'b1;
  end

  // final verdict
  initial begin
    wait (run_done || timed_out);
    if (timed_out) $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
    if (scan_status_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, scan_status_q.size());
    if (!timed_out && scan_status_q.size() == 0 && mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/lmts_pkg.sv
rtl/lmts_cfg_regs.sv
rtl/lmts_core.sv
rtl/lcd_mode_timing_sequencer.sv
tb/lcd_mode_timing_sequencer_tb.sv
